>>> rtl/mtb_pkg.sv
package mtb_pkg;

  // Storage geometry. The field widths of the transaction types are fixed by the interface.
  localparam int unsigned NUM_LISTS  = 4;
  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned ENTRY_W    = 4;
  localparam int unsigned SEL_W      = 2;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned ORDER_W    = 64;
  localparam int unsigned LIST_IDX_W = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  localparam logic [LEN_W-1:0] FULL_COUNT_RESET = LEN_W'(13);

  typedef logic [LIST_DEPTH-1:0][ENTRY_W-1:0] row_t;

  typedef struct packed {
    logic [SEL_W-1:0]   list_select;
    logic [ENTRY_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]   list_length;
    logic               was_present;
    logic               is_full;
    logic [ORDER_W-1:0] order_packed;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input and read the selected list row
    logic commit;  // write the updated row and length, load the result register
  } mtb_cmd_t;

endpackage

>>> rtl/mtb_ctrl.sv
module mtb_ctrl import mtb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output mtb_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_PROC
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.commit = (state_q == ST_PROC) && (!out_valid_q || !out_stall_i);

    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) begin
          state_d = ST_PROC;
        end
      end
      ST_PROC: begin
        if (cmd_o.commit) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/mtb_datapath.sv
module mtb_datapath import mtb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mtb_cmd_t         cmd_i,
  input  in_item_t         in_item_i,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i,
  output out_item_t        out_item_o
);

  // One row per list, written and read as a whole.
  row_t                  mem_q [NUM_LISTS];
  row_t                  row_q;
  logic [LIST_IDX_W-1:0] sel_q;
  logic [ENTRY_W-1:0]    value_q;
  logic [LEN_W-1:0]      len_q [NUM_LISTS];
  logic [LEN_W-1:0]      full_count_q;
  out_item_t             out_q;

  logic [LIST_IDX_W-1:0] in_idx;
  logic [LEN_W-1:0]      len_cur;
  logic [LEN_W-1:0]      len_d;
  logic [LEN_W-1:0]      tail;
  logic [LIST_DEPTH-1:0] match;
  logic [LIST_DEPTH-1:0] seen;
  logic                  present;
  row_t                  row_shift;
  row_t                  row_d;
  row_t                  row_out;

  // The select field is reduced modulo the number of lists.
  assign in_idx  = LIST_IDX_W'(in_item_i.list_select);
  assign len_cur = len_q[sel_q];

  always_comb begin
    for (int i = 0; i < LIST_DEPTH; i++) begin
      match[i] = (row_q[i] == value_q) && (LEN_W'(i) < len_cur);
    end
    present = |match;
    // Entries at and after the match take their right neighbor.
    for (int i = 0; i < LIST_DEPTH; i++) begin
      seen[i] = |(match & LIST_DEPTH'((2 ** (i + 1)) - 1));
    end
    row_shift = row_t'(row_q >> ENTRY_W);
    tail      = present ? (len_cur - LEN_W'(1)) : len_cur;
    if (!present && (len_cur < LEN_W'(LIST_DEPTH))) begin
      len_d = len_cur + LEN_W'(1);
    end else begin
      len_d = len_cur;
    end
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (LEN_W'(i) == tail) begin
        row_d[i] = value_q;
      end else if (seen[i]) begin
        row_d[i] = row_shift[i];
      end else begin
        row_d[i] = row_q[i];
      end
      row_out[i] = (LEN_W'(i) < len_d) ? row_d[i] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      row_q   <= mem_q[in_idx];
      sel_q   <= in_idx;
      value_q <= in_item_i.value;
    end
    if (cmd_i.commit) begin
      mem_q[sel_q]           <= row_d;
      out_q.list_length      <= len_d;
      out_q.was_present      <= present;
      out_q.is_full          <= (len_d == full_count_q);
      out_q.order_packed     <= ORDER_W'(row_out);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        len_q[i] <= '0;
      end
      full_count_q <= FULL_COUNT_RESET;
    end else begin
      if (cmd_i.commit) begin
        len_q[sel_q] <= len_d;
      end
      if (cfg_we_i) begin
        full_count_q <= cfg_wdata_i;
      end
    end
  end

  assign out_item_o = out_q;

endmodule

>>> rtl/move_to_back_recency_lists.sv
// Channel   Direction  Handshake                 Payload
// input     in         in_valid_i / in_stall_o   in_item_i   (list_select, value)
// output    out        out_valid_o / out_stall_i out_item_o  (length, flags, order)
// config    in         cfg_we_i                  cfg_wdata_i (full_count)
//
// A transaction first reads the selected list row from the row memory into a register,
// then searches it, rebuilds it and writes it back. The next transaction is accepted
// only after the write back, so a following transaction on the same list always sees
// the updated row. Reset clears all list lengths and loads full_count with 13; the row
// memory is not cleared, since entries beyond a list's length are never used.
// A stalled output holds the finished result and keeps a new one waiting in the datapath,
// and the input stays stalled until that new result can be committed.
module move_to_back_recency_lists import mtb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i
);

  mtb_cmd_t cmd;

  // The controller sequences the read and the commit of each transaction and owns
  // the result valid flag.
  mtb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the lists, the lengths, the full count and the result register.
  mtb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_item_o  (out_item_o)
  );

  // An accepted transaction always blocks the input for the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on two consecutive cycles");

  // A list never reports more entries than it can hold.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.list_length <= LEN_W'(LIST_DEPTH))
    else $error("list length beyond depth");

  // A value that was found implies a non-empty list.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.was_present |-> out_item_o.list_length != '0)
    else $error("value reported present in an empty list");

  // Results appear only after the commit cycle of a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a transaction in flight");

endmodule

>>> test/tb_move_to_back_recency_lists.sv
`timescale 1ns / 1ps

// Testbench for the move-to-back recency lists.
//
// The block keeps four ordered lists of distinct 4-bit values, oldest first. Each input
// transaction names a list and a value. A value that is absent is appended, and one that
// is present is moved to the back. The block returns one result per transaction: the new
// length, whether the value was there already, the full flag, and the packed list.
//
// The bench keeps its own copy of every list and of full_count. When an input
// transaction is accepted, the bench computes the expected result and queues it. A
// checker process compares each accepted output transaction, field by field, against
// the oldest queued expectation.
//
// The stimulus runs as a series of test tasks:
//   - test_fill_list fills list 0 to its depth. It passes through the reset value of
//     full_count and then 16, and moves values out of the middle and the front.
//   - test_move_to_back uses full_count = 1 on short lists. It covers an append, a move
//     from the front, a touch of the last entry (no change), and the other lists.
//   - test_random_phase runs several rounds of random traffic, each under its own
//     full_count. Among those settings are 0 and 31, which never report full.
// In the random rounds, lists 1 to 3 draw their values from a range that widens from round
// to round, so short lists and appends keep turning up late in the run. The list select
// tends to repeat, which gives back-to-back transactions on one list. Some values are
// chosen to touch the entry that is already last.
//
// A full list that receives an absent value cannot occur here. A list at full depth holds
// all sixteen 4-bit values, so any value is present in it.
module tb_move_to_back_recency_lists;
  import mtb_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASE_ITEMS  = 190;
  localparam int NUM_PHASES   = 7;
  localparam int DRAIN_CYCLES = 8;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_item_t         in_item_i;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_we_i;
  logic [LEN_W-1:0] cfg_wdata_i;

  // The bench's own copy of the lists, their lengths and the full count.
  logic [ENTRY_W-1:0] recency_entries [NUM_LISTS][LIST_DEPTH];
  logic [LEN_W-1:0]   recency_lengths [NUM_LISTS];
  logic [LEN_W-1:0]   full_count_q;

  out_item_t expected_results [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  bit        no_idle = 1'b0;

  move_to_back_recency_lists DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // The receiver stalls in about one cycle out of ten. It does not stall while the
  // no-idle stretch is active.
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(0, 99) < 10);
  end

  // If the run hangs, this ends it.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** move_to_back_recency_lists: FAILED **");
      $finish;
    end
  end

  // This applies one transaction to the bench's copy of the lists and returns the result
  // that the block should give. The search finds the first match, closes the gap behind
  // it, and puts the value at the back. An absent value is appended while there is room.
  function automatic out_item_t touch_list(in_item_t item);
    int        sel;
    int        len;
    int        pos;
    bit        found;
    out_item_t res;
    sel   = item.list_select % NUM_LISTS;
    len   = int'(recency_lengths[sel]);
    pos   = len;
    found = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (!found && recency_entries[sel][i] == item.value) begin
        pos   = i;
        found = 1'b1;
      end
    end
    if (found) begin
      for (int i = pos; i + 1 < len; i++) begin
        recency_entries[sel][i] = recency_entries[sel][i + 1];
      end
      recency_entries[sel][len - 1] = item.value;
    end else if (len < LIST_DEPTH) begin
      recency_entries[sel][len] = item.value;
      len++;
    end
    recency_lengths[sel] = LEN_W'(len);
    res.list_length  = LEN_W'(len);
    res.was_present  = found;
    res.is_full      = (LEN_W'(len) == full_count_q);
    res.order_packed = '0;
    for (int i = 0; i < len; i++) begin
      res.order_packed[ENTRY_W*i +: ENTRY_W] = recency_entries[sel][i];
    end
    return res;
  endfunction

  // This sends one input transaction. The task is entered at a rising edge and returns
  // at the edge that accepts the transaction, with valid still high. A following call
  // can therefore present the next transaction with no gap. The expected result is
  // queued at the edge that accepts the transaction.
  task automatic send_item(input logic [SEL_W-1:0] sel, input logic [ENTRY_W-1:0] val);
    in_item_t item;
    item.list_select = sel;
    item.value       = val;
    if (!no_idle && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    expected_results.push_back(touch_list(item));
  endtask

  // Every transaction produces a result. The block is therefore idle once the queue is
  // empty, and only then is the register written.
  task automatic write_full_count(input logic [LEN_W-1:0] fc);
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fc;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    full_count_q  = fc;
  endtask

  // List 0 first reaches the reset full count of 13, and then its full depth under a
  // count of 16. A value is then pulled out of the middle, and one out of the front.
  task automatic test_fill_list();
    for (int v = 0; v < 13; v++) send_item(2'd0, ENTRY_W'(v));
    write_full_count(LEN_W'(16));
    for (int v = 13; v < 16; v++) send_item(2'd0, ENTRY_W'(v));
    send_item(2'd0, 4'd7);
    send_item(2'd0, 4'd0);
  endtask

  // These are short lists under a full count of 1. The first append reports full. The
  // value 15 is then moved from the front, and touched again while it is already last.
  task automatic test_move_to_back();
    write_full_count(LEN_W'(1));
    send_item(2'd3, 4'd15);
    send_item(2'd3, 4'd0);
    send_item(2'd3, 4'd15);
    send_item(2'd3, 4'd15);
    send_item(2'd1, 4'd5);
    send_item(2'd2, 4'd10);
    send_item(2'd1, 4'd5);
  endtask

  // This is one round of random traffic under a given full count. The value bound of
  // lists 1 to 3 grows with the round number, so they fill gradually; list 0 uses 0 to 15.
  // A tenth of the values touch the last entry, and a tenth use the whole 4-bit range.
  task automatic test_random_phase(input int phase, input logic [LEN_W-1:0] fc);
    logic [SEL_W-1:0]   sel;
    logic [ENTRY_W-1:0] val;
    int                 cap;
    int                 len;
    int                 pick;
    write_full_count(fc);
    sel = SEL_W'($urandom_range(0, NUM_LISTS - 1));
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(0, 1)) sel = SEL_W'($urandom_range(0, NUM_LISTS - 1));
      cap = (sel == 0) ? 15 : 2 * phase + 4 * (int'(sel) - 1) + 1;
      if (cap > 15) cap = 15;
      len  = int'(recency_lengths[sel]);
      pick = $urandom_range(0, 99);
      if (pick < 10 && len > 0) begin
        val = recency_entries[sel][len - 1];
      end else if (pick < 20) begin
        val = ENTRY_W'($urandom_range(0, 15));
      end else begin
        val = ENTRY_W'($urandom_range(0, cap));
      end
      send_item(sel, val);
    end
  endtask

  // This checks each accepted output transaction against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_item_o);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.list_length !== want.list_length) begin
          $display("%0t: list_length expected %0d actual %0d", $time,
                   want.list_length, out_item_o.list_length);
          mismatch_count++;
        end
        if (out_item_o.was_present !== want.was_present) begin
          $display("%0t: was_present expected %0b actual %0b", $time,
                   want.was_present, out_item_o.was_present);
          mismatch_count++;
        end
        if (out_item_o.is_full !== want.is_full) begin
          $display("%0t: is_full expected %0b actual %0b", $time,
                   want.is_full, out_item_o.is_full);
          mismatch_count++;
        end
        if (out_item_o.order_packed !== want.order_packed) begin
          $display("%0t: order_packed expected %h actual %h", $time,
                   want.order_packed, out_item_o.order_packed);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [LEN_W-1:0] phase_full_count [NUM_PHASES];
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    for (int l = 0; l < NUM_LISTS; l++) begin
      recency_lengths[l] = '0;
      for (int i = 0; i < LIST_DEPTH; i++) recency_entries[l][i] = '0;
    end
    full_count_q = FULL_COUNT_RESET;

    // The full count for each random round. The list covers both ends of the legal range,
    // the reset value, and the settings 0 and 31 that can never match.
    phase_full_count[0] = LEN_W'(31);
    phase_full_count[1] = LEN_W'(13);
    phase_full_count[2] = LEN_W'(0);
    phase_full_count[3] = LEN_W'($urandom_range(1, 16));
    phase_full_count[4] = LEN_W'(8);
    phase_full_count[5] = LEN_W'(16);
    phase_full_count[6] = LEN_W'(1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_list();
    test_move_to_back();
    for (int p = 0; p < NUM_PHASES; p++) begin
      // In round 3 neither side idles or stalls.
      no_idle = (p == 3);
      test_random_phase(p, phase_full_count[p]);
    end
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("** move_to_back_recency_lists: PASSED **");
    end else begin
      $display("** move_to_back_recency_lists: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mtb_pkg.sv
rtl/mtb_ctrl.sv
rtl/mtb_datapath.sv
rtl/move_to_back_recency_lists.sv
test/tb_move_to_back_recency_lists.sv
